>>> hw/rtl/imm_pkg.sv
// Shared types and constants of the integer matrix multiply unit.
// No dependencies; imported by imm_ctrl, imm_dp and the top level.
package imm_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_W     = 4;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned OP_W      = 2;

  // operation codes; the fourth code is unused and ignored
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_B_COLS = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_a;    // write value into left store at its fill count
    logic load_b;    // write value into right store at its fill count
    logic run_init;  // compute accepted: clear fills, rewind pointers
    logic issue;     // read one A/B element pair
    logic first;     // first term of a dot product
    logic last_k;    // last term of a dot product
    logic emit;      // load the output register
    logic err;       // emitted beat is a size error
    logic last;      // emitted beat ends the run
    logic col_wrap;  // element was the last of its row
  } imm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic acc_done;  // dot product complete in accumulator
    logic out_free;  // output register can take a beat
  } imm_stat_t;

endpackage

>>> hw/rtl/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/imm_dp.sv
// Datapath: configuration registers, element stores, address pointers,
// multiply-accumulate pipeline and output register. Uses imm_pkg, imm_ram.
module imm_dp #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [imm_pkg::REG_IDX_W-1:0]           cfg_idx_i,
  input  logic [imm_pkg::REG_W-1:0]               cfg_data_i,
  input  logic [imm_pkg::DATA_W-1:0]              value_i,
  input  imm_pkg::imm_cmd_t                       cmd_i,
  output imm_pkg::imm_stat_t                      stat_o,
  output logic [$clog2(MAX_DIM+1)-1:0]            dim_m_o,
  output logic [$clog2(MAX_DIM+1)-1:0]            dim_n_o,
  output logic [$clog2(MAX_DIM+1)-1:0]            dim_kb_o,
  output logic [$clog2(MAX_DIM+1)-1:0]            dim_p_o,
  input  logic                                    out_stall_i,
  output logic                                    out_valid_o,
  output logic signed [imm_pkg::DATA_W-1:0]       product_o,
  output logic                                    last_o,
  output logic                                    size_error_o
);
  import imm_pkg::*;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned SZ_W   = 2 * DIM_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] raw);
    logic [DIM_W-1:0] res;
    if (raw == '0) begin
      res = DIM_W'(1);
    end else if (int'(raw) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(raw);
    end
    return res;
  endfunction

  // configuration
  logic [REG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= REG_W'(1);
      a_cols_q <= REG_W'(1);
      b_rows_q <= REG_W'(1);
      b_cols_q <= REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A_ROWS: a_rows_q <= cfg_data_i;
        REG_A_COLS: a_cols_q <= cfg_data_i;
        REG_B_ROWS: b_rows_q <= cfg_data_i;
        REG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] m, n, kb, p;
  assign m  = clamp_dim(a_rows_q);
  assign n  = clamp_dim(a_cols_q);
  assign kb = clamp_dim(b_rows_q);
  assign p  = clamp_dim(b_cols_q);

  assign dim_m_o  = m;
  assign dim_n_o  = n;
  assign dim_kb_o = kb;
  assign dim_p_o  = p;

  // fill counters
  logic [FILL_W-1:0] a_fill_q, b_fill_q;
  logic [SZ_W-1:0]   a_size, b_size;
  logic              a_wr, b_wr;

  assign a_size = SZ_W'(m) * SZ_W'(n);
  assign b_size = SZ_W'(kb) * SZ_W'(p);
  assign a_wr   = cmd_i.load_a && (SZ_W'(a_fill_q) < a_size);
  assign b_wr   = cmd_i.load_b && (SZ_W'(b_fill_q) < b_size);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_fill_q <= '0;
      b_fill_q <= '0;
    end else if (cmd_i.run_init) begin
      a_fill_q <= '0;
      b_fill_q <= '0;
    end else begin
      if (a_wr) a_fill_q <= a_fill_q + FILL_W'(1);
      if (b_wr) b_fill_q <= b_fill_q + FILL_W'(1);
    end
  end

  // per-entry valid bits: an entry never written reads as zero
  logic [DEPTH-1:0] a_vld_q, b_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= '0;
      b_vld_q <= '0;
    end else begin
      if (a_wr) a_vld_q[a_fill_q[AW-1:0]] <= 1'b1;
      if (b_wr) b_vld_q[b_fill_q[AW-1:0]] <= 1'b1;
    end
  end

  // address pointers: row base i*n, column j, running k offsets
  logic [AW-1:0] a_row_q, a_ptr_q, b_col_q, b_ptr_q;
  logic [AW-1:0] a_raddr, b_raddr;

  assign a_raddr = cmd_i.first ? a_row_q : a_ptr_q;
  assign b_raddr = cmd_i.first ? b_col_q : b_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_row_q <= '0;
      a_ptr_q <= '0;
      b_col_q <= '0;
      b_ptr_q <= '0;
    end else if (cmd_i.run_init) begin
      a_row_q <= '0;
      b_col_q <= '0;
    end else begin
      if (cmd_i.issue) begin
        a_ptr_q <= a_raddr + AW'(1);
        b_ptr_q <= b_raddr + AW'(p);
      end
      if (cmd_i.emit) begin
        if (cmd_i.col_wrap) begin
          a_row_q <= a_row_q + AW'(n);
          b_col_q <= '0;
        end else begin
          b_col_q <= b_col_q + AW'(1);
        end
      end
    end
  end

  // stores
  logic [DATA_W-1:0] a_rdata, b_rdata;

  imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (a_wr),
    .waddr_i (a_fill_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (b_wr),
    .waddr_i (b_fill_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // read stage tags and valid bits
  logic s1_vld_q, s1_first_q, s1_last_q;
  logic a_ev_q, b_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.issue;
      s1_first_q <= cmd_i.first;
      s1_last_q  <= cmd_i.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ev_q <= a_vld_q[a_raddr];
    b_ev_q <= b_vld_q[b_raddr];
  end

  // multiply stage, low 32 bits only
  logic [DATA_W-1:0] a_el, b_el, prod_d, prod_q;
  logic              s2_vld_q, s2_first_q, s2_last_q;

  assign a_el   = a_ev_q ? a_rdata : '0;
  assign b_el   = b_ev_q ? b_rdata : '0;
  assign prod_d = a_el * b_el;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // accumulate
  logic [DATA_W-1:0] acc_q;
  logic              acc_done_q;

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_q <= s2_first_q ? prod_q : acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_done_q <= 1'b0;
    end else begin
      acc_done_q <= s2_vld_q && s2_last_q;
    end
  end

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] product_q;
  logic              last_q, size_error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      product_q    <= cmd_i.err ? '0 : acc_q;
      last_q       <= cmd_i.last;
      size_error_q <= cmd_i.err;
    end
  end

  assign stat_o.acc_done = acc_done_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign product_o    = product_q;
  assign last_o       = last_q;
  assign size_error_o = size_error_q;

endmodule

>>> hw/rtl/imm_ctrl.sv
// Controller: accepts input beats and sequences the i/j/k loops of a compute
// run. Uses imm_pkg.
module imm_ctrl #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [imm_pkg::OP_W-1:0]            operation_i,
  output logic                                in_stall_o,
  input  logic [$clog2(MAX_DIM+1)-1:0]        dim_m_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]        dim_n_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]        dim_kb_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]        dim_p_i,
  input  imm_pkg::imm_stat_t                  stat_i,
  output imm_pkg::imm_cmd_t                   cmd_o
);
  import imm_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W = $clog2(MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] i_q, j_q, k_q;
  logic             err_q;

  logic accept, k_last, j_last, i_last;

  assign accept = in_valid_i && !in_stall_o;
  assign k_last = DIM_W'(k_q) == (dim_n_i - DIM_W'(1));
  assign j_last = DIM_W'(j_q) == (dim_p_i - DIM_W'(1));
  assign i_last = DIM_W'(i_q) == (dim_m_i - DIM_W'(1));

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_a   = accept && (operation_i == OP_LOAD_A);
    cmd_o.load_b   = accept && (operation_i == OP_LOAD_B);
    cmd_o.run_init = accept && (operation_i == OP_COMPUTE);
    cmd_o.issue    = (state_q == ST_ISSUE);
    cmd_o.first    = (k_q == '0);
    cmd_o.last_k   = k_last;
    cmd_o.emit     = (state_q == ST_EMIT) && stat_i.out_free;
    cmd_o.err      = err_q;
    cmd_o.last     = err_q || (i_last && j_last);
    cmd_o.col_wrap = j_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      err_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (operation_i == OP_COMPUTE)) begin
            i_q   <= '0;
            j_q   <= '0;
            k_q   <= '0;
            err_q <= (dim_n_i != dim_kb_i);
            state_q <= (dim_n_i != dim_kb_i) ? ST_EMIT : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + CNT_W'(1);
          end
        end
        ST_WAIT: begin
          if (stat_i.acc_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (stat_i.out_free) begin
            if (err_q || (i_last && j_last)) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_ISSUE;
              if (j_last) begin
                j_q <= '0;
                i_q <= i_q + CNT_W'(1);
              end else begin
                j_q <= j_q + CNT_W'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/integer_matrix_multiply_unit.sv
// Top level of the integer matrix multiply unit: controller plus datapath.
// Depends on imm_pkg, imm_ctrl, imm_dp (and imm_ram through imm_dp).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o | operation_i, value_i
//  out     | output    | out_valid_o/out_stall_i | product_o, last_o, size_error_o
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Loads are accepted whenever no compute run is active.
// In a compute run, each product element issues n store reads, then waits
// for the RAM read, multiply and accumulate stages and an emit step; a size
// mismatch goes from the accepting beat straight to the emit step.
// Reset needs no clearing pass: per-entry valid bits make unwritten entries
// read as zero. A stalled output beat holds the run in its emit step.
module integer_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [imm_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [imm_pkg::REG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [imm_pkg::OP_W-1:0]          operation_i,
  input  logic signed [imm_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [imm_pkg::DATA_W-1:0] product_o,
  output logic                              last_o,
  output logic                              size_error_o
);
  import imm_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  imm_cmd_t         cmd;
  imm_stat_t        stat;
  logic [DIM_W-1:0] dim_m, dim_n, dim_kb, dim_p;

  imm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .dim_m_i     (dim_m),
    .dim_n_i     (dim_n),
    .dim_kb_i    (dim_kb),
    .dim_p_i     (dim_p),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  imm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .dim_m_o      (dim_m),
    .dim_n_o      (dim_n),
    .dim_kb_o     (dim_kb),
    .dim_p_o      (dim_p),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .product_o    (product_o),
    .last_o       (last_o),
    .size_error_o (size_error_o)
  );

`ifndef ASSERT_OFF
  // an error beat is always the single, final, zero beat of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && size_error_o) |-> (last_o && (product_o == '0)))
    else $error("size error beat without last or with nonzero product");

  // a compute beat starts a run that blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (operation_i == OP_COMPUTE)) |=> in_stall_o)
    else $error("input accepted right after a compute beat");

  // a finished dot product only shows up inside a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.acc_done |-> in_stall_o)
    else $error("accumulator completion outside a compute run");

  // the controller never overwrites a beat the sink has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");
`endif

endmodule

>>> sim/tb_integer_matrix_multiply_unit.sv
// Self-checking bench for integer_matrix_multiply_unit: directed table, then random
// load/compute sequences checked against an in-bench matrix product tracker.
// Depends on imm_pkg and the unit's RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imm_pkg::*;

  localparam int unsigned MAX_DIM       = 8;
  localparam int unsigned DEPTH         = MAX_DIM * MAX_DIM;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned TARGET_BEATS  = 410;
  localparam int unsigned CALM_AFTER    = 330;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned STALL_LIMIT   = 4000;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic              last;
    logic              size_error;
  } mm_result_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

  // code is an operation for ROW_BEAT and a register index for ROW_REG
  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        code;
    logic [DATA_W-1:0] data;
    logic              typed;
    mm_result_t        result;
  } plan_row_t;

  localparam mm_result_t NO_RESULT = '0;
  localparam int unsigned PLAN_ROWS = 30;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [REG_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [OP_W-1:0]          operation_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] product_o;
  logic                     last_o;
  logic                     size_error_o;

  // tracked block state
  logic [DATA_W-1:0] left_mem [DEPTH] = '{default: '0};
  logic [DATA_W-1:0] right_mem [DEPTH] = '{default: '0};
  int unsigned       left_fill = 0;
  int unsigned       right_fill = 0;
  logic [REG_W-1:0]  a_rows = REG_W'(1), a_cols = REG_W'(1);
  logic [REG_W-1:0]  b_rows = REG_W'(1), b_cols = REG_W'(1);

  mm_result_t  pending_products [$];
  int unsigned beats_taken = 0;
  int unsigned computes = 0;
  int unsigned settings = 0;
  int unsigned results_seen = 0;
  int unsigned size_errors = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_BEAT, OP_COMPUTE, 32'h0,        1'b1, '{32'h0, 1'b1, 1'b0}},
    '{ROW_BEAT, OP_LOAD_A,  32'h7fffffff, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_B,  32'h7fffffff, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_COMPUTE, 32'h0,        1'b1, '{32'h1, 1'b1, 1'b0}},
    '{ROW_BEAT, OP_LOAD_A,  32'h80000000, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_A,  32'h5,        1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_B,  32'hffffffff, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_COMPUTE, 32'h0,        1'b1, '{32'h80000000, 1'b1, 1'b0}},
    '{ROW_BEAT, OP_UNUSED,  32'hffffffff, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_COMPUTE, 32'hffffffff, 1'b1, '{32'h80000000, 1'b1, 1'b0}},
    '{ROW_REG,  REG_A_COLS, 32'd2,        1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_A,  32'h3,        1'b0, NO_RESULT},
    '{ROW_BEAT, OP_COMPUTE, 32'h0,        1'b1, '{32'h0, 1'b1, 1'b1}},
    '{ROW_REG,  REG_A_COLS, 32'd0,        1'b0, NO_RESULT},
    '{ROW_REG,  REG_B_ROWS, 32'd15,       1'b0, NO_RESULT},
    '{ROW_BEAT, OP_COMPUTE, 32'h0,        1'b1, '{32'h0, 1'b1, 1'b1}},
    '{ROW_REG,  REG_B_ROWS, 32'd0,        1'b0, NO_RESULT},
    '{ROW_REG,  REG_A_ROWS, 32'd15,       1'b0, NO_RESULT},
    '{ROW_REG,  REG_B_COLS, 32'd9,        1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_A,  32'h12345678, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_A,  32'h80000001, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_B,  32'hfffffffe, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_B,  32'h7fffffff, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_COMPUTE, 32'h0,        1'b0, NO_RESULT},
    '{ROW_REG,  REG_A_ROWS, 32'd2,        1'b0, NO_RESULT},
    '{ROW_REG,  REG_A_COLS, 32'd3,        1'b0, NO_RESULT},
    '{ROW_REG,  REG_B_ROWS, 32'd3,        1'b0, NO_RESULT},
    '{ROW_REG,  REG_B_COLS, 32'd2,        1'b0, NO_RESULT},
    '{ROW_BEAT, OP_LOAD_A,  32'hffffffff, 1'b0, NO_RESULT},
    '{ROW_BEAT, OP_COMPUTE, 32'h0,        1'b0, NO_RESULT}
  };

  integer_matrix_multiply_unit #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .product_o    (product_o),
    .last_o       (last_o),
    .size_error_o (size_error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [REG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return 32'(raw);
  endfunction

  function automatic logic [REG_W-1:0] rand_dim();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return REG_W'($urandom_range(1, 4));
    if (sel < 9) return REG_W'($urandom_range(5, 8));
    return $urandom_range(0, 1) ? '0 : REG_W'($urandom_range(9, 15));
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'h1;
      default: return 32'h0;
    endcase
  endfunction

  // Applies one accepted beat to the tracked state and queues the product beats
  // it causes; a typed row supplies its own single result instead.
  task automatic matmul_step(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                             input logic typed, input mm_result_t typed_res);
    mm_result_t        run_q [$];
    mm_result_t        r;
    logic [DATA_W-1:0] acc;
    int unsigned       m, n, kb, p;
    case (op)
      OP_LOAD_A: begin
        if (left_fill < clamp_dim(a_rows) * clamp_dim(a_cols)) begin
          left_mem[left_fill] = val;
          left_fill++;
          beats_taken++;
        end
      end
      OP_LOAD_B: begin
        if (right_fill < clamp_dim(b_rows) * clamp_dim(b_cols)) begin
          right_mem[right_fill] = val;
          right_fill++;
          beats_taken++;
        end
      end
      OP_COMPUTE: begin
        m = clamp_dim(a_rows);
        n = clamp_dim(a_cols);
        kb = clamp_dim(b_rows);
        p = clamp_dim(b_cols);
        left_fill = 0;
        right_fill = 0;
        beats_taken++;
        computes++;
        if (n != kb) begin
          run_q.push_back('{'0, 1'b1, 1'b1});
        end else begin
          for (int unsigned i = 0; i < m; i++) begin
            for (int unsigned j = 0; j < p; j++) begin
              acc = '0;
              for (int unsigned k = 0; k < n; k++) begin
                acc = acc + left_mem[(i * n + k) % DEPTH] * right_mem[(k * p + j) % DEPTH];
              end
              r.product = acc;
              r.last = (i == m - 1) && (j == p - 1);
              r.size_error = 1'b0;
              run_q.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
    if (typed) begin
      pending_products.push_back(typed_res);
    end else begin
      foreach (run_q[q]) pending_products.push_back(run_q[q]);
    end
    calm = (beats_taken >= CALM_AFTER);
  endtask

  // Offers one beat, holds it while stalled; returns at the accepting edge.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic typed, input mm_result_t typed_res);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    value_i <= val;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    matmul_step(op, val, typed, typed_res);
  endtask

  // Register writes only once every product beat is out and the block is idle.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    wait (pending_products.size() == 0);
    @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_A_ROWS: a_rows = data;
      REG_A_COLS: a_cols = data;
      REG_B_ROWS: b_rows = data;
      REG_B_COLS: b_cols = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [REG_W-1:0] ar, ac, br, bc;
    int unsigned      seqs, shape, a_len, b_len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        quiesce();
        write_reg(plan[r].code, plan[r].data[REG_W-1:0]);
      end else begin
        send_beat(plan[r].code, plan[r].data, plan[r].typed, plan[r].result);
      end
    end

    while (beats_taken < TARGET_BEATS) begin
      ar = rand_dim();
      ac = rand_dim();
      br = ($urandom_range(0, 6) == 0) ? rand_dim() : ac;
      bc = rand_dim();
      quiesce();
      settings++;
      // one setting runs under a long output hold-off so the input backs up
      if (settings == 3) br = ac;
      write_reg(REG_A_ROWS, ar);
      write_reg(REG_A_COLS, ac);
      write_reg(REG_B_ROWS, br);
      write_reg(REG_B_COLS, bc);
      seqs = $urandom_range(1, 3);
      if (settings == 3) begin
        seqs = 3;
        hold_off_req = 1'b1;
      end
      repeat (seqs) begin
        shape = (settings == 3) ? 9 : $urandom_range(0, 9);
        a_len = clamp_dim(ar) * clamp_dim(ac);
        b_len = clamp_dim(br) * clamp_dim(bc);
        if (shape == 0) begin
          a_len = $urandom_range(0, a_len);
          b_len = $urandom_range(0, b_len);
        end else if (shape == 1) begin
          a_len += $urandom_range(1, 3);
          b_len += $urandom_range(1, 3);
        end
        repeat (a_len) send_beat(OP_LOAD_A, rand_value(), 1'b0, NO_RESULT);
        if (shape == 2) send_beat(OP_UNUSED, rand_value(), 1'b0, NO_RESULT);
        repeat (b_len) send_beat(OP_LOAD_B, rand_value(), 1'b0, NO_RESULT);
        if (shape == 3) begin
          repeat ($urandom_range(1, 4)) send_beat(OP_W'($urandom_range(0, 3)), rand_value(),
                                                  1'b0, NO_RESULT);
        end
        send_beat(OP_COMPUTE, $urandom, 1'b0, NO_RESULT);
      end
    end

    in_valid_i <= 1'b0;
    wait (pending_products.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d matrix beats over %0d random register settings, %0d compute runs.",
             beats_taken, settings, computes);
    $display("Checked %0d product beats, %0d of them size errors.", results_seen, size_errors);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Everything is sampled mid-cycle, where the handshake for the next edge is settled.
  always @(negedge clk_i) begin : product_check
    mm_result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_products.size() == 0) begin
          $display("%0t: unexpected beat: product %0d last %0b size_error %0b",
                   $time, product_o, last_o, size_error_o);
          mismatches++;
        end else begin
          want = pending_products.pop_front();
          if (want.size_error) size_errors++;
          if (product_o !== want.product) begin
            $display("%0t: product expected %0d, got %0d", $time,
                     $signed(want.product), product_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, last_o);
            mismatches++;
          end
          if (size_error_o !== want.size_error) begin
            $display("%0t: size_error expected %0b, got %0b", $time,
                     want.size_error, size_error_o);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

>>> files.f
hw/rtl/imm_pkg.sv
hw/rtl/imm_ram.sv
hw/rtl/imm_dp.sv
hw/rtl/imm_ctrl.sv
hw/rtl/integer_matrix_multiply_unit.sv
sim/tb_integer_matrix_multiply_unit.sv
